// ===== src/sfn_pkg.sv =====
// sfn_pkg: constants, widths and the control state type of the spectral flux block
// used by spectral_flux_novelty and sfn_checker; no dependencies
package sfn_pkg;

  localparam int CHANNELS   = 2;
  localparam int MAX_BINS   = 1024;

  localparam int AMP_W      = 16;               // amplitude and Q8.8 root width
  localparam int CNT_W      = 11;               // bin_count register width
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int SUM_W      = 28;               // signed frame sum
  localparam int DIV_W      = SUM_W - 1;        // magnitude of the sum
  localparam int NOV_W      = 17;               // signed Q8.8 novelty
  localparam int ADDR_W     = $clog2(CHANNELS * MAX_BINS);
  localparam int STEP_W     = $clog2(DIV_W + 1);

  localparam int S_DATA_W   = 16;
  localparam int S_USER_W   = 2;
  localparam int M_DATA_W   = 24;
  localparam int M_USER_W   = 1;

  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_BIN_COUNT   = 1'b0;
  localparam logic [CNT_W-1:0]     BIN_COUNT_RESET = CNT_W'(1024);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_UPDATE,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ===== src/sfn_ram.sv =====
// sfn_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module sfn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/spectral_flux_novelty.sv =====
// spectral_flux_novelty: per-frame mean of root-amplitude differences against the last frame
// depends on sfn_pkg and sfn_ram
//
//   channel  dir  handshake        payload
//   s_*      in   tvalid/tready    tdata: amplitude; tuser: chan, first_frame
//   m_*      out  tvalid/tready    tdata: novelty (17b signed); tuser: out_chan
//   apb      in   psel/penable     bin_count at byte address 0
//
// one word at a time: each word passes through the 16 two-bit steps of the
// shared square-root unit, then the read-modify-write of the root store.
// the word that closes a frame adds a bit-serial divide and the load of
// the output register, which holds its word while the next frame is accepted.
// rst is synchronous; the root store needs no clearing, as its read is ignored on a first_frame word.
module spectral_flux_novelty (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sfn_pkg::S_DATA_W-1:0]  s_tdata,   // [15:0] amplitude
  input  logic [sfn_pkg::S_USER_W-1:0]  s_tuser,   // [0] chan, [1] first_frame
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sfn_pkg::M_DATA_W-1:0]  m_tdata,   // [16:0] novelty, rest zero
  output logic [sfn_pkg::M_USER_W-1:0]  m_tuser,   // [0] out_chan
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfn_pkg::PADDR_W-1:0]   paddr,
  input  logic [sfn_pkg::PDATA_W-1:0]   pwdata,
  output logic [sfn_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AMP_W  = sfn_pkg::AMP_W;
  localparam int CNT_W  = sfn_pkg::CNT_W;
  localparam int BIN_W  = sfn_pkg::BIN_W;
  localparam int SUM_W  = sfn_pkg::SUM_W;
  localparam int DIV_W  = sfn_pkg::DIV_W;
  localparam int NOV_W  = sfn_pkg::NOV_W;
  localparam int ADDR_W = sfn_pkg::ADDR_W;
  localparam int STEP_W = sfn_pkg::STEP_W;

  sfn_pkg::state_t state, state_next;

  logic [CNT_W-1:0]   bin_count;
  logic [CNT_W-1:0]   eff_count;
  logic [BIN_W-1:0]   bin_index;
  logic signed [SUM_W-1:0] diff_sum;

  // item held while it is worked on
  logic               it_first;
  logic               it_chan;
  logic               it_last;
  logic [ADDR_W-1:0]  it_slot;
  logic [CNT_W-1:0]   it_count;

  logic [STEP_W-1:0]  step_cnt;

  // square-root unit
  logic [2*AMP_W-1:0] rt_rad;
  logic [AMP_W:0]     rt_rem;
  logic [AMP_W-1:0]   rt_root;
  logic [AMP_W+2:0]   rt_shift;
  logic [AMP_W+2:0]   rt_trial;
  logic               rt_ge;

  // divider
  logic [DIV_W-1:0]   dv_quo;
  logic [CNT_W-1:0]   dv_rem;
  logic               dv_neg;
  logic [CNT_W:0]     dv_shift;
  logic               dv_ge;
  logic [DIV_W-1:0]   dv_signed;

  logic [NOV_W-1:0]   out_nov;
  logic               out_chan;

  logic               accept;
  logic               cfg_write;
  logic               out_free;
  logic               root_step;
  logic               div_step;
  logic               do_update;
  logic               load_out;

  logic [ADDR_W-1:0]  acc_slot;
  logic [ADDR_W-1:0]  ch_base;
  logic               acc_last;
  logic [AMP_W-1:0]   ram_rdata;
  logic [AMP_W-1:0]   prev_root;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]   sum_mag;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2 +: sfn_pkg::REG_IDX_W] == sfn_pkg::REG_BIN_COUNT);
  assign prdata    = (paddr[2 +: sfn_pkg::REG_IDX_W] == sfn_pkg::REG_BIN_COUNT) ?
                     sfn_pkg::PDATA_W'(bin_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= sfn_pkg::BIN_COUNT_RESET;
    end else if (cfg_write) begin
      bin_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (bin_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (bin_count > CNT_W'(sfn_pkg::MAX_BINS)) begin
      eff_count = CNT_W'(sfn_pkg::MAX_BINS);
    end else begin
      eff_count = bin_count;
    end
  end

  // control
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      sfn_pkg::ST_IDLE:   if (s_tvalid) state_next = sfn_pkg::ST_ROOT;
      sfn_pkg::ST_ROOT:   if (step_cnt == STEP_W'(1)) state_next = sfn_pkg::ST_UPDATE;
      sfn_pkg::ST_UPDATE: state_next = it_last ? sfn_pkg::ST_DIV : sfn_pkg::ST_IDLE;
      sfn_pkg::ST_DIV:    if (step_cnt == STEP_W'(1)) state_next = sfn_pkg::ST_EMIT;
      sfn_pkg::ST_EMIT:   if (out_free) state_next = sfn_pkg::ST_IDLE;
      default:            state_next = sfn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    root_step = 1'b0;
    do_update = 1'b0;
    div_step  = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      sfn_pkg::ST_IDLE:   s_tready  = !rst;
      sfn_pkg::ST_ROOT:   root_step = 1'b1;
      sfn_pkg::ST_UPDATE: do_update = 1'b1;
      sfn_pkg::ST_DIV:    div_step  = 1'b1;
      sfn_pkg::ST_EMIT:   load_out  = out_free;
      default:            s_tready  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store address: out-of-range channels share the last channel's rows
  always_comb begin
    if (32'(s_tuser[0]) >= sfn_pkg::CHANNELS) begin
      ch_base = ADDR_W'((sfn_pkg::CHANNELS - 1) * sfn_pkg::MAX_BINS);
    end else begin
      ch_base = ADDR_W'(32'(s_tuser[0]) * sfn_pkg::MAX_BINS);
    end
  end

  assign acc_slot = ch_base + ADDR_W'(bin_index);
  assign acc_last = ((CNT_W+1)'(bin_index) + (CNT_W+1)'(1)) >= (CNT_W+1)'(eff_count);

  sfn_ram #(
    .WIDTH (AMP_W),
    .DEPTH (sfn_pkg::CHANNELS * sfn_pkg::MAX_BINS)
  ) u_roots (
    .clk   (clk),
    .we    (do_update),
    .waddr (it_slot),
    .wdata (rt_root),
    .re    (accept),
    .raddr (acc_slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      it_first <= s_tuser[1];
      it_chan  <= s_tuser[0];
      it_last  <= acc_last;
      it_slot  <= acc_slot;
      it_count <= eff_count;
    end
  end

  // square root: two radicand bits per cycle, amplitude scaled by 2^16
  assign rt_shift = {rt_rem, rt_rad[2*AMP_W-1 -: 2]};
  assign rt_trial = {1'b0, rt_root, 2'b01};
  assign rt_ge    = rt_shift >= rt_trial;

  always_ff @(posedge clk) begin
    if (accept) begin
      rt_rad  <= {s_tdata[AMP_W-1:0], AMP_W'(0)};
      rt_rem  <= '0;
      rt_root <= '0;
    end else if (root_step) begin
      rt_rad  <= {rt_rad[2*AMP_W-3:0], 2'b00};
      rt_rem  <= rt_ge ? (AMP_W+1)'(rt_shift - rt_trial) : rt_shift[AMP_W:0];
      rt_root <= {rt_root[AMP_W-2:0], rt_ge};
    end
  end

  // read-modify-write of the root store and the frame sum
  assign prev_root = it_first ? '0 : ram_rdata;
  assign sum_new   = diff_sum
                   + $signed({(SUM_W-AMP_W)'(0), rt_root})
                   - $signed({(SUM_W-AMP_W)'(0), prev_root});
  assign sum_mag   = sum_new[SUM_W-1] ? (~sum_new + SUM_W'(1)) : sum_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_index <= '0;
      diff_sum  <= '0;
    end else if (do_update) begin
      if (it_last) begin
        bin_index <= '0;
        diff_sum  <= '0;
      end else begin
        bin_index <= bin_index + BIN_W'(1);
        diff_sum  <= sum_new;
      end
    end
  end

  // restoring divide of the magnitude, one quotient bit per cycle
  assign dv_shift  = {dv_rem, dv_quo[DIV_W-1]};
  assign dv_ge     = dv_shift >= {1'b0, it_count};
  assign dv_signed = dv_neg ? (~dv_quo + DIV_W'(1)) : dv_quo;

  always_ff @(posedge clk) begin
    if (do_update) begin
      dv_quo <= sum_mag[DIV_W-1:0];
      dv_rem <= '0;
      dv_neg <= sum_new[SUM_W-1];
    end else if (div_step) begin
      dv_quo <= {dv_quo[DIV_W-2:0], dv_ge};
      dv_rem <= dv_ge ? CNT_W'(dv_shift - {1'b0, it_count}) : dv_shift[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (accept) begin
      step_cnt <= STEP_W'(AMP_W);
    end else if (do_update) begin
      step_cnt <= STEP_W'(DIV_W);
    end else if (root_step || div_step) begin
      step_cnt <= step_cnt - STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_nov  <= dv_signed[NOV_W-1:0];
      out_chan <= it_chan;
    end
  end

  assign m_tdata = {(sfn_pkg::M_DATA_W-NOV_W)'(0), out_nov};
  assign m_tuser = out_chan;

endmodule

// ===== src/sfn_checker.sv =====
// sfn_checker: port-level checks for spectral_flux_novelty, bound to the top level
// depends on sfn_pkg
module sfn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sfn_pkg::M_DATA_W-1:0]  m_tdata,   // [16:0] novelty, rest zero
  input logic [sfn_pkg::M_USER_W-1:0]  m_tuser    // [0] out_chan
);

  // a stalled word keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // nothing comes out the cycle after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // one word is worked on at a time, so no accept directly follows another
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // padding above the novelty field stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[sfn_pkg::M_DATA_W-1:sfn_pkg::NOV_W] == '0)
    else $error("output padding not zero");

endmodule

bind spectral_flux_novelty sfn_checker u_sfn_checker (.*);
